@@ src/mcu_pkg.sv @@
// Package: shared constants, codes and control structs of the correlation unit.
`timescale 1ns / 1ps
package mcu_pkg;

  localparam int unsigned CountWidthDef = 16;
  localparam int unsigned QBits         = 16;
  localparam int unsigned FracShift     = 30;

  localparam logic [1:0] CLS_ZERO = 2'd0;
  localparam logic [1:0] CLS_ONE  = 2'd1;

  typedef enum logic [2:0] {
    SEL_POS = 3'd0,
    SEL_NEG = 3'd1,
    SEL_PA  = 3'd2,
    SEL_PB  = 3'd3,
    SEL_DEN = 3'd4,
    SEL_TGT = 3'd5
  } mul_sel_e;

  typedef struct packed {
    logic     count_en;
    logic     mul_load;
    logic     mul_step;
    logic     store;
    mul_sel_e sel;
    logic     sq_init;
    logic     sq_step;
    logic     finish;
  } mcu_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic sq_last;
    logic zero_den;
  } mcu_sts_t;

endpackage

@@ src/mcu_if.sv @@
// Interfaces: label pair channel and correlation result channel.
`timescale 1ns / 1ps
interface mcu_pair_if;
  logic       valid;
  logic       ready;
  logic [1:0] true_class;
  logic [1:0] pred_class;
  logic       last_pair;
  modport source (output valid, true_class, pred_class, last_pair, input ready);
  modport sink (input valid, true_class, pred_class, last_pair, output ready);
endinterface

interface mcu_result_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] mcc_value;
  logic              zero_denominator;
  logic              count_overflow;
  modport source (output valid, mcc_value, zero_denominator, count_overflow, input ready);
  modport sink (input valid, mcc_value, zero_denominator, count_overflow, output ready);
endinterface

@@ src/mcu_ctrl.sv @@
// Controller: sequences counting, products, root search and result hand-off.
`timescale 1ns / 1ps
module mcu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_pair_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output mcu_pkg::mcu_cmd_t cmd_o,
  input  mcu_pkg::mcu_sts_t sts_i
);
  import mcu_pkg::*;

  typedef enum logic [6:0] {
    ST_COUNT  = 7'b0000001,
    ST_CHECK  = 7'b0000010,
    ST_LOAD   = 7'b0000100,
    ST_MUL    = 7'b0001000,
    ST_STORE  = 7'b0010000,
    ST_SQRT   = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

  state_e   state_q, state_d;
  mul_sel_e sel_q, sel_d;
  logic     pend_q, pend_d;

  always_comb begin
    state_d    = state_q;
    sel_d      = sel_q;
    cmd_o      = '0;
    cmd_o.sel  = sel_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_COUNT: begin
        in_ready_o     = 1'b1;
        cmd_o.count_en = in_valid_i;
        if (in_valid_i && last_pair_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        sel_d = SEL_POS;
        if (sts_i.zero_den) state_d = ST_FINISH;
        else state_d = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.mul_load = 1'b1;
        state_d        = ST_MUL;
      end
      ST_MUL: begin
        if (sts_i.mul_done) state_d = ST_STORE;
        else cmd_o.mul_step = 1'b1;
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        unique case (sel_q)
          SEL_POS: begin sel_d = SEL_NEG; state_d = ST_LOAD; end
          SEL_NEG: begin sel_d = SEL_PA;  state_d = ST_LOAD; end
          SEL_PA:  begin sel_d = SEL_PB;  state_d = ST_LOAD; end
          SEL_PB:  begin sel_d = SEL_DEN; state_d = ST_LOAD; end
          SEL_DEN: begin sel_d = SEL_TGT; state_d = ST_LOAD; end
          default: begin
            cmd_o.sq_init = 1'b1;
            state_d       = ST_SQRT;
          end
        endcase
      end
      ST_SQRT: begin
        cmd_o.sq_step = 1'b1;
        if (sts_i.sq_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!pend_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_COUNT;
        end
      end
      default: state_d = ST_COUNT;
    endcase
  end

  always_comb begin
    pend_d = pend_q;
    if (pend_q && out_ready_i) pend_d = 1'b0;
    if (cmd_o.finish) pend_d = 1'b1;
  end

  assign out_valid_o = pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COUNT;
      sel_q   <= SEL_POS;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      pend_q  <= pend_d;
    end
  end

endmodule

@@ src/mcu_datapath.sv @@
// Datapath: confusion counters, shift-add multiplier, bitwise root search.
`timescale 1ns / 1ps
module mcu_datapath #(
  parameter int unsigned COUNT_WIDTH = mcu_pkg::CountWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mcu_pkg::mcu_cmd_t  cmd_i,
  output mcu_pkg::mcu_sts_t  sts_o,
  input  logic [1:0]         true_class_i,
  input  logic [1:0]         pred_class_i,
  output logic signed [15:0] mcc_value_o,
  output logic               zero_denominator_o,
  output logic               count_overflow_o
);
  import mcu_pkg::*;

  localparam int unsigned SW  = COUNT_WIDTH + 1;
  localparam int unsigned MW  = 2 * SW;
  localparam int unsigned DW  = 2 * MW;
  localparam int unsigned PW  = DW + 2 * QBits + 1;
  localparam int unsigned QDW = DW + QBits;
  localparam int unsigned CNW = $clog2(MW + 1);
  localparam int unsigned BW  = $clog2(QBits);

  localparam logic [COUNT_WIDTH-1:0] Bound = '1;

  logic [COUNT_WIDTH-1:0] tp_q, fp_q, fn_q, tn_q;
  logic                   sat_q;
  logic [SW-1:0]          s1, s2, s3, s4;
  logic [MW-1:0]          pos_q, neg_q, pa_q, pb_q, nm;
  logic                   negative;
  logic [DW-1:0]          den_q;
  logic [PW-1:0]          tgt_q;
  logic [DW-1:0]          mul_a_q, mul_acc_q;
  logic [MW-1:0]          mul_b_q, op_a, op_b;
  logic [CNW-1:0]         mul_cnt_q;
  logic [QBits-1:0]       q_q;
  logic [PW-1:0]          p_q, cand;
  logic [QDW-1:0]         qd_q;
  logic [BW-1:0]          bit_q;
  logic [QBits-1:0]       bit_mask;
  logic signed [15:0]     mcc_q;
  logic                   zd_q, ov_q;
  logic                   hit_tp, hit_fp, hit_fn, hit_tn;

  assign s1 = SW'(tp_q) + SW'(fp_q);
  assign s2 = SW'(tp_q) + SW'(fn_q);
  assign s3 = SW'(tn_q) + SW'(fp_q);
  assign s4 = SW'(tn_q) + SW'(fn_q);

  assign negative = neg_q > pos_q;
  assign nm       = negative ? neg_q - pos_q : pos_q - neg_q;

  assign hit_tp = (true_class_i == CLS_ONE)  && (pred_class_i == CLS_ONE);
  assign hit_fp = (true_class_i == CLS_ZERO) && (pred_class_i == CLS_ONE);
  assign hit_fn = (true_class_i == CLS_ONE)  && (pred_class_i == CLS_ZERO);
  assign hit_tn = (true_class_i == CLS_ZERO) && (pred_class_i == CLS_ZERO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tp_q  <= '0;
      fp_q  <= '0;
      fn_q  <= '0;
      tn_q  <= '0;
      sat_q <= 1'b0;
    end else if (cmd_i.finish) begin
      tp_q  <= '0;
      fp_q  <= '0;
      fn_q  <= '0;
      tn_q  <= '0;
      sat_q <= 1'b0;
    end else if (cmd_i.count_en) begin
      if (hit_tp) begin
        if (tp_q == Bound) sat_q <= 1'b1;
        else tp_q <= tp_q + 1'b1;
      end
      if (hit_fp) begin
        if (fp_q == Bound) sat_q <= 1'b1;
        else fp_q <= fp_q + 1'b1;
      end
      if (hit_fn) begin
        if (fn_q == Bound) sat_q <= 1'b1;
        else fn_q <= fn_q + 1'b1;
      end
      if (hit_tn) begin
        if (tn_q == Bound) sat_q <= 1'b1;
        else tn_q <= tn_q + 1'b1;
      end
    end
  end

  always_comb begin
    case (cmd_i.sel)
      SEL_POS: begin op_a = MW'(tp_q); op_b = MW'(tn_q); end
      SEL_NEG: begin op_a = MW'(fp_q); op_b = MW'(fn_q); end
      SEL_PA:  begin op_a = MW'(s1);   op_b = MW'(s2);   end
      SEL_PB:  begin op_a = MW'(s3);   op_b = MW'(s4);   end
      SEL_DEN: begin op_a = pa_q;      op_b = pb_q;      end
      default: begin op_a = nm;        op_b = nm;        end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_cnt_q <= '0;
    end else if (cmd_i.mul_load) begin
      mul_cnt_q <= '0;
    end else if (cmd_i.mul_step) begin
      mul_cnt_q <= mul_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      mul_a_q   <= DW'(op_a);
      mul_b_q   <= op_b;
      mul_acc_q <= '0;
    end else if (cmd_i.mul_step) begin
      if (mul_b_q[0]) mul_acc_q <= mul_acc_q + mul_a_q;
      mul_a_q <= mul_a_q << 1;
      mul_b_q <= mul_b_q >> 1;
    end
    if (cmd_i.store) begin
      case (cmd_i.sel)
        SEL_POS: pos_q <= mul_acc_q[MW-1:0];
        SEL_NEG: neg_q <= mul_acc_q[MW-1:0];
        SEL_PA:  pa_q  <= mul_acc_q[MW-1:0];
        SEL_PB:  pb_q  <= mul_acc_q[MW-1:0];
        SEL_DEN: den_q <= mul_acc_q;
        default: tgt_q <= PW'(mul_acc_q) << FracShift;
      endcase
    end
  end

  assign bit_mask = QBits'(1) << bit_q;
  assign cand = p_q + (PW'(qd_q) << ({1'b0, bit_q} + 1'b1))
                    + (PW'(den_q) << {bit_q, 1'b0});

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_init) begin
      q_q   <= '0;
      p_q   <= '0;
      qd_q  <= '0;
      bit_q <= BW'(QBits - 1);
    end else if (cmd_i.sq_step) begin
      if (cand <= tgt_q) begin
        q_q  <= q_q | bit_mask;
        p_q  <= cand;
        qd_q <= qd_q + (QDW'(den_q) << bit_q);
      end
      bit_q <= bit_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      zd_q <= sts_o.zero_den;
      ov_q <= sat_q;
      if (sts_o.zero_den) mcc_q <= 16'sh8000;
      else if (negative) mcc_q <= -$signed(q_q);
      else if (q_q[QBits-1]) mcc_q <= 16'sh7fff;
      else mcc_q <= $signed(q_q);
    end
  end

  assign sts_o.mul_done = mul_cnt_q == CNW'(MW);
  assign sts_o.sq_last  = bit_q == '0;
  assign sts_o.zero_den = (s1 == '0) || (s2 == '0) || (s3 == '0) || (s4 == '0);

  assign mcc_value_o        = mcc_q;
  assign zero_denominator_o = zd_q;
  assign count_overflow_o   = ov_q;

endmodule

@@ src/matthews_correlation_unit.sv @@
// Top level: Matthews correlation over a stream of label pairs.
//
//  channel  | dir | transaction
//  pair_i   | in  | true_class, pred_class, last_pair
//  result_o | out | mcc_value, zero_denominator, count_overflow
//
// Ordinary pairs are counted at one per cycle while no result is being computed.
// A last pair starts the bit-serial shift-add multiplier, used for six products,
// and then the 16-step root search; a zero denominator skips both.
// A finished result waits in an output register; pairs are taken meanwhile.
// Reset clears the counters and the control state.
`timescale 1ns / 1ps
module matthews_correlation_unit #(
  parameter int unsigned COUNT_WIDTH = mcu_pkg::CountWidthDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  mcu_pair_if.sink     pair_i,
  mcu_result_if.source result_o
);
  import mcu_pkg::*;

  mcu_cmd_t cmd;
  mcu_sts_t sts;

  mcu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pair_i.valid),
    .last_pair_i (pair_i.last_pair),
    .in_ready_o  (pair_i.ready),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mcu_datapath #(.COUNT_WIDTH(COUNT_WIDTH)) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .true_class_i       (pair_i.true_class),
    .pred_class_i       (pair_i.pred_class),
    .mcc_value_o        (result_o.mcc_value),
    .zero_denominator_o (result_o.zero_denominator),
    .count_overflow_o   (result_o.count_overflow)
  );

endmodule

@@ src/mcu_checker.sv @@
// Checker: port-level properties of the correlation unit, bound to the top level.
`timescale 1ns / 1ps
module mcu_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              last_pair_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic signed [15:0] mcc_value_i,
  input logic              zero_denominator_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(mcc_value_i))
    else $error("result dropped or changed while stalled");

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && last_pair_i |=> !in_ready_i)
    else $error("pair taken while result is being computed");

  a_zero_den_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && zero_denominator_i |-> mcc_value_i == 16'sh8000)
    else $error("zero denominator without -1.0 value");

endmodule

bind matthews_correlation_unit mcu_checker u_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (pair_i.valid),
  .in_ready_i         (pair_i.ready),
  .last_pair_i        (pair_i.last_pair),
  .out_valid_i        (result_o.valid),
  .out_ready_i        (result_o.ready),
  .mcc_value_i        (result_o.mcc_value),
  .zero_denominator_i (result_o.zero_denominator)
);
